>>> hdl/ttc_pkg.sv
// Shared constants, payload types, controller states and control structs of the correlator.
package ttc_pkg;

    // Sizes of the stores and of the histogram
    localparam int MAX_BINS  = 64;
    localparam int MAX_TAGS  = 1024;
    localparam int TAG_WIDTH = 48;

    localparam int TAG_IDX_W = $clog2(MAX_TAGS);
    localparam int TAG_CNT_W = $clog2(MAX_TAGS + 1);
    localparam int BIN_IDX_W = 6;
    localparam int NB_W      = 7;
    localparam int COUNT_W   = 21;
    localparam int OFF_W     = 41;
    localparam int DIFF_W    = TAG_WIDTH + 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0]   COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [TAG_CNT_W-1:0] TAGS_FULL = TAG_CNT_W'(MAX_TAGS);
    localparam logic [NB_W-1:0]      NB_MAX    = NB_W'(MAX_BINS);
    localparam logic [NB_W-1:0]      NB_RESET  = NB_W'(64);

    // Request codes
    localparam logic [1:0] REQ_LOAD_LEFT  = 2'd0;
    localparam logic [1:0] REQ_LOAD_RIGHT = 2'd1;
    localparam logic [1:0] REQ_RUN        = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BIN_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS         = 1'd1;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [TAG_WIDTH-1:0] tag_time;
    } t_in_word;

    typedef struct packed {
        logic [BIN_IDX_W-1:0] bin_index;
        logic [COUNT_W-1:0]   bin_count;
        logic                 last_bin;
        logic                 tags_dropped;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_LRD,
        S_LCAP,
        S_RRD,
        S_CLS,
        S_DEC,
        S_HINC,
        S_ERD,
        S_EOUT,
        S_EWAIT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic in_fire;
        logic run_init;
        logic left_cap;
        logic diff_calc;
        logic below;
        logic hist_rd;
        logic hist_inc;
        logic j_next;
        logic i_next;
        logic emit_load;
        logic emit_pop;
        logic clear_all;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic run_req;
        logic any_empty;
        logic cls_below;
        logic cls_above;
        logic j_last;
        logic i_last;
        logic bin_last;
        logic out_taken;
    } t_sts;

endpackage

>>> hdl/ttc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ttc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/ttc_dp.sv
// Datapath: tag stores, scan counters, difference unit, histogram and output register.
module ttc_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ttc_pkg::t_in_word              i_in_data,
    input  logic                           i_cfg_valid,
    input  logic [ttc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ttc_pkg::OFF_W-1:0]      i_cfg_data,
    input  logic                           i_out_ready,
    input  ttc_pkg::t_cmd                  i_cmd,
    output ttc_pkg::t_sts                  o_sts,
    output logic                           o_out_valid,
    output ttc_pkg::t_out_word             o_out_data
);
    import ttc_pkg::*;

    // Configuration
    logic [OFF_W-1:0] r_first_bin_offset;
    logic [NB_W-1:0]  r_num_bins;

    // Load and scan state
    logic [TAG_CNT_W-1:0] r_left_cnt, n_left_cnt;
    logic [TAG_CNT_W-1:0] r_right_cnt, n_right_cnt;
    logic                 r_ovf, n_ovf;
    logic [TAG_IDX_W-1:0] r_i, n_i;
    logic [TAG_IDX_W-1:0] r_j, n_j;
    logic [TAG_IDX_W-1:0] r_ssp, n_ssp;
    logic [TAG_WIDTH-1:0] r_left;
    logic [DIFF_W-1:0]    r_diff;
    logic [BIN_IDX_W-1:0] r_hidx;
    logic [BIN_IDX_W-1:0] r_bin, n_bin;
    logic [MAX_BINS-1:0]  r_hvalid, n_hvalid;
    logic                 r_out_valid, n_out_valid;
    t_out_word            r_out;

    logic [TAG_WIDTH-1:0] left_rdata, right_rdata;
    logic [COUNT_W-1:0]   hist_rdata, hist_cur, hist_wdata;
    logic [BIN_IDX_W-1:0] hist_raddr;
    logic                 left_we, right_we, left_full, right_full;
    logic                 is_left, is_right;
    logic [NB_W-1:0]      nb_eff;
    logic [BIN_IDX_W-1:0] nb_last;
    logic [DIFF_W-1:0]    off_ext, diff_calc;

    assign is_left    = (i_in_data.req_type == REQ_LOAD_LEFT);
    assign is_right   = (i_in_data.req_type == REQ_LOAD_RIGHT);
    assign left_full  = (r_left_cnt == TAGS_FULL);
    assign right_full = (r_right_cnt == TAGS_FULL);
    assign left_we    = i_cmd.in_fire && is_left && !left_full;
    assign right_we   = i_cmd.in_fire && is_right && !right_full;

    // Clamp the bin count into 1..MAX_BINS
    always_comb begin
        if (r_num_bins == '0) begin
            nb_eff = NB_W'(1);
        end else if (r_num_bins > NB_MAX) begin
            nb_eff = NB_MAX;
        end else begin
            nb_eff = r_num_bins;
        end
    end
    assign nb_last = BIN_IDX_W'(nb_eff - NB_W'(1));

    // Tag stores
    ttc_ram #(.WIDTH(TAG_WIDTH), .DEPTH(MAX_TAGS)) u_left_store (
        .i_clk   (i_clk),
        .i_we    (left_we),
        .i_waddr (r_left_cnt[TAG_IDX_W-1:0]),
        .i_wdata (i_in_data.tag_time),
        .i_raddr (r_i),
        .o_rdata (left_rdata)
    );

    ttc_ram #(.WIDTH(TAG_WIDTH), .DEPTH(MAX_TAGS)) u_right_store (
        .i_clk   (i_clk),
        .i_we    (right_we),
        .i_waddr (r_right_cnt[TAG_IDX_W-1:0]),
        .i_wdata (i_in_data.tag_time),
        .i_raddr (r_j),
        .o_rdata (right_rdata)
    );

    // Histogram; a bin with its valid bit clear reads as zero
    assign hist_raddr = i_cmd.hist_rd ? r_diff[BIN_IDX_W-1:0] : r_bin;
    assign hist_cur   = r_hvalid[r_hidx] ? hist_rdata : '0;
    assign hist_wdata = (hist_cur == COUNT_MAX) ? hist_cur : hist_cur + COUNT_W'(1);

    ttc_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_BINS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.hist_inc),
        .i_waddr (r_hidx),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    // Difference right - left - offset, exact in DIFF_W bits
    assign off_ext   = {{(DIFF_W - OFF_W){r_first_bin_offset[OFF_W-1]}}, r_first_bin_offset};
    assign diff_calc = {2'b00, right_rdata} - {2'b00, r_left} - off_ext;

    // Next values of the control registers
    always_comb begin
        n_left_cnt  = r_left_cnt;
        n_right_cnt = r_right_cnt;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_ssp       = r_ssp;
        n_bin       = r_bin;
        n_hvalid    = r_hvalid;
        n_out_valid = r_out_valid;

        if (left_we) begin
            n_left_cnt = r_left_cnt + TAG_CNT_W'(1);
        end
        if (right_we) begin
            n_right_cnt = r_right_cnt + TAG_CNT_W'(1);
        end
        if (i_cmd.in_fire && ((is_left && left_full) || (is_right && right_full))) begin
            n_ovf = 1'b1;
        end
        if (i_cmd.run_init) begin
            n_i   = '0;
            n_ssp = '0;
            n_bin = '0;
        end
        if (i_cmd.left_cap) begin
            n_j = r_ssp;
        end
        if (i_cmd.below) begin
            n_ssp = r_j;
        end
        if (i_cmd.j_next) begin
            n_j = r_j + TAG_IDX_W'(1);
        end
        if (i_cmd.i_next) begin
            n_i = r_i + TAG_IDX_W'(1);
        end
        if (i_cmd.hist_inc) begin
            n_hvalid[r_hidx] = 1'b1;
        end
        if (i_cmd.emit_load) begin
            n_out_valid = 1'b1;
        end
        if (o_sts.out_taken) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.emit_pop) begin
            n_bin = r_bin + BIN_IDX_W'(1);
        end
        if (i_cmd.clear_all) begin
            n_left_cnt  = '0;
            n_right_cnt = '0;
            n_ovf       = 1'b0;
            n_ssp       = '0;
            n_hvalid    = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_bin_offset <= '0;
            r_num_bins         <= NB_RESET;
            r_left_cnt         <= '0;
            r_right_cnt        <= '0;
            r_ovf              <= 1'b0;
            r_i                <= '0;
            r_j                <= '0;
            r_ssp              <= '0;
            r_bin              <= '0;
            r_hvalid           <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_index == CFG_FIRST_BIN_OFFSET) begin
                r_first_bin_offset <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == CFG_NUM_BINS) begin
                r_num_bins <= i_cfg_data[NB_W-1:0];
            end
            r_left_cnt  <= n_left_cnt;
            r_right_cnt <= n_right_cnt;
            r_ovf       <= n_ovf;
            r_i         <= n_i;
            r_j         <= n_j;
            r_ssp       <= n_ssp;
            r_bin       <= n_bin;
            r_hvalid    <= n_hvalid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: left tag, difference, bin address, output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.left_cap) begin
            r_left <= left_rdata;
        end
        if (i_cmd.diff_calc) begin
            r_diff <= diff_calc;
        end
        if (i_cmd.hist_rd) begin
            r_hidx <= r_diff[BIN_IDX_W-1:0];
        end
        if (i_cmd.emit_load) begin
            r_out.bin_index    <= r_bin;
            r_out.bin_count    <= r_hvalid[r_bin] ? hist_rdata : '0;
            r_out.last_bin     <= (r_bin == nb_last);
            r_out.tags_dropped <= r_ovf;
        end
    end

    // Status back to the controller
    always_comb begin
        o_sts.run_req   = (i_in_data.req_type == REQ_RUN);
        o_sts.any_empty = (r_left_cnt == '0) || (r_right_cnt == '0);
        o_sts.cls_below = r_diff[DIFF_W-1];
        o_sts.cls_above = !r_diff[DIFF_W-1] && (r_diff >= DIFF_W'(nb_eff));
        o_sts.j_last    = ({1'b0, r_j} + TAG_CNT_W'(1)) >= r_right_cnt;
        o_sts.i_last    = ({1'b0, r_i} + TAG_CNT_W'(1)) >= r_left_cnt;
        o_sts.bin_last  = (r_bin == nb_last);
        o_sts.out_taken = r_out_valid && i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hdl/ttc_ctrl.sv
// Controller: sequences loading, the pair scan and the histogram emit.
module ttc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ttc_pkg::t_sts i_sts,
    output ttc_pkg::t_cmd o_cmd
);
    import ttc_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.run_req) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = i_sts.any_empty ? S_ERD : S_LRD;
            end
            S_LRD:  n_state = S_LCAP;
            S_LCAP: n_state = S_RRD;
            S_RRD:  n_state = S_CLS;
            S_CLS:  n_state = S_DEC;
            S_DEC: begin
                if (i_sts.cls_above) begin
                    n_state = i_sts.i_last ? S_ERD : S_LRD;
                end else if (i_sts.cls_below) begin
                    if (!i_sts.j_last) begin
                        n_state = S_RRD;
                    end else begin
                        n_state = i_sts.i_last ? S_ERD : S_LRD;
                    end
                end else begin
                    n_state = S_HINC;
                end
            end
            S_HINC: begin
                if (!i_sts.j_last) begin
                    n_state = S_RRD;
                end else begin
                    n_state = i_sts.i_last ? S_ERD : S_LRD;
                end
            end
            S_ERD:  n_state = S_EOUT;
            S_EOUT: n_state = S_EWAIT;
            S_EWAIT: begin
                if (i_sts.out_taken) begin
                    n_state = i_sts.bin_last ? S_IDLE : S_ERD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.in_fire = i_in_valid;
            end
            S_START: begin
                o_cmd.run_init = 1'b1;
            end
            S_LCAP: begin
                o_cmd.left_cap = 1'b1;
            end
            S_CLS: begin
                o_cmd.diff_calc = 1'b1;
            end
            S_DEC: begin
                if (i_sts.cls_above) begin
                    o_cmd.i_next = !i_sts.i_last;
                end else if (i_sts.cls_below) begin
                    o_cmd.below  = 1'b1;
                    o_cmd.j_next = !i_sts.j_last;
                    o_cmd.i_next = i_sts.j_last && !i_sts.i_last;
                end else begin
                    o_cmd.hist_rd = 1'b1;
                end
            end
            S_HINC: begin
                o_cmd.hist_inc = 1'b1;
                o_cmd.j_next   = !i_sts.j_last;
                o_cmd.i_next   = i_sts.j_last && !i_sts.i_last;
            end
            S_EOUT: begin
                o_cmd.emit_load = 1'b1;
            end
            S_EWAIT: begin
                o_cmd.emit_pop  = i_sts.out_taken && !i_sts.bin_last;
                o_cmd.clear_all = i_sts.out_taken && i_sts.bin_last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> hdl/time_tag_correlator_unit_bins.sv
// Top level of the time-tag cross-correlator with unit-width bins.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): a word either loads a
// tag into the left or right store, or starts a run. Back-to-back words are
// accepted while idle. A tag offered to a full store is dropped and
// flagged in tags_dropped of the next histogram.
// Configuration channel (i_cfg_*): always ready; write only while idle.
// A run passes a start state, then walks the stores unless one is empty:
// read and capture states per left tag, read, classify and decide states
// per right tag compared, an increment state per pair counted, set by the
// registered read ports of the tag stores and histogram RAM. The histogram
// then leaves as output words, one per bin from bin 0 up, last_bin on the last.
// When the receiver stalls, the word is held and the block waits.
// No input word is accepted during a run or emit. After the last word is
// taken the stores, histogram and overflow flag are empty again.
// Reset: synchronous, active low; clears counts, flags and control registers, no
// clearing pass is needed (histogram bins carry valid bits).
module time_tag_correlator_unit_bins (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ttc_pkg::t_in_word             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ttc_pkg::t_out_word            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ttc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ttc_pkg::OFF_W-1:0]     i_cfg_data
);
    import ttc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

    ttc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ttc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

>>> hdl/ttc_chk.sv
// Port-level checker for the correlator, bound to the top level.
module ttc_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input ttc_pkg::t_in_word             i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input ttc_pkg::t_out_word            o_out_data
);
    import ttc_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // No loads are taken while a histogram is being emitted
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input accepted during emit");

    // A run word that is taken drops input ready
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.req_type == REQ_RUN |=> !o_in_ready)
        else $error("input ready right after a run word");

    // The top bin is always the last one
    a_top_bin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.bin_index == BIN_IDX_W'(MAX_BINS - 1)
            |-> o_out_data.last_bin)
        else $error("top bin without last marker");

    // Nothing follows the last bin directly
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.last_bin |=> !o_out_valid)
        else $error("result word after last bin");

endmodule

bind time_tag_correlator_unit_bins ttc_chk u_ttc_chk (.*);
